>>> rtl/core/box_average_downscaler_unit_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef BOX_AVERAGE_DOWNSCALER_UNIT_DEFINES_SVH
`define BOX_AVERAGE_DOWNSCALER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define BAD_ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BAD_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define BAD_ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define BAD_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/core/bad_pkg.sv
`default_nettype none
package bad_pkg;
    localparam int MAX_WIDTH = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int SIZE_W = 12;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int SUM_W = 30;
    localparam int PIX_W = 8;
    localparam int CH = 4;
    localparam int AREA_W = 2 * SIZE_W - 1;
    localparam int QBITS = PIX_W;
    localparam int RAM_W = CH * SUM_W;

    typedef logic [CH-1:0][SUM_W-1:0] sum_vec_t;
    typedef logic [CH-1:0][PIX_W-1:0] pix_vec_t;

    typedef enum logic [1:0]
    {
        REG_SOURCE_WIDTH = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_TARGET_WIDTH = 2'd2,
        REG_TARGET_HEIGHT = 2'd3
    } reg_index_t;
endpackage
`default_nettype wire

>>> rtl/core/bad_ram.sv
`default_nettype none
module bad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/bad_div.sv
`default_nettype none
module bad_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [bad_pkg::SIZE_W-1:0] dividend,
    input  wire logic [bad_pkg::SIZE_W-1:0] divisor,
    output logic                            busy,
    output logic      [bad_pkg::SIZE_W-1:0] quotient,
    output logic      [bad_pkg::SIZE_W-1:0] remainder
);
    localparam int CNT_W = $clog2(bad_pkg::SIZE_W);

    logic                       busy_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [bad_pkg::SIZE_W:0]   rem_reg;
    logic [bad_pkg::SIZE_W-1:0] quo_reg;
    logic [bad_pkg::SIZE_W:0]   trial;
    logic                       fits;

    assign trial = {rem_reg[bad_pkg::SIZE_W-1:0], quo_reg[bad_pkg::SIZE_W-1]};
    assign fits = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            count_reg <= CNT_W'(bad_pkg::SIZE_W - 1);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial - {1'b0, divisor} : trial;
            quo_reg <= {quo_reg[bad_pkg::SIZE_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg[bad_pkg::SIZE_W-1:0];
endmodule
`default_nettype wire

>>> rtl/core/bad_avg.sv
`default_nettype none
module bad_avg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire bad_pkg::sum_vec_t          sums,
    input  wire logic [bad_pkg::AREA_W-1:0] area,
    output logic                            done,
    output bad_pkg::pix_vec_t               quotients
);
    localparam int CNT_W = $clog2(bad_pkg::QBITS);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CNT_W-1:0]          count_reg;
    bad_pkg::sum_vec_t         rem_reg;
    logic [bad_pkg::SUM_W-1:0] dsh_reg;
    bad_pkg::pix_vec_t         quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                count_reg <= CNT_W'(bad_pkg::QBITS - 1);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= sums;
            dsh_reg <= bad_pkg::SUM_W'({area, (bad_pkg::QBITS - 1)'(0)});
        end
        else if (busy_reg)
        begin
            dsh_reg <= dsh_reg >> 1;
            for (int c = 0; c < bad_pkg::CH; c++)
            begin
                if (rem_reg[c] >= dsh_reg)
                begin
                    rem_reg[c] <= rem_reg[c] - dsh_reg;
                    quo_reg[c] <= {quo_reg[c][bad_pkg::QBITS-2:0], 1'b1};
                end
                else
                begin
                    quo_reg[c] <= {quo_reg[c][bad_pkg::QBITS-2:0], 1'b0};
                end
            end
        end
    end

    assign done = done_reg;
    assign quotients = quo_reg;
endmodule
`default_nettype wire

>>> rtl/core/box_average_downscaler_unit.sv
// Box-average image downscaler.
// Source pixels enter on the s_axis channel in raster order, one RGBA pixel
// per beat. Averaged output pixels leave on the m_axis channel, and tlast
// marks the last output pixel of a frame. Frames follow back to back.
// Sizes are set through the APB port; a write restarts the frame and then
// the block computes the window size with s_axis_tready low until it is
// done. Each pixel takes two steps: one to read the column sum memory and
// one to write it back. A pixel that completes a window then waits on the
// 8-step shift-subtract divider that forms the four channel averages.
// The result waits in an output register, so the next pixel is taken while
// the receiver stalls; a second result waits until that register frees up.
// After reset all sizes are 2048 and the position is at the start of a
// frame; the sum memory needs no clearing since every window row 0 writes
// its entry before it is read.
`default_nettype none
`include "box_average_downscaler_unit_defines.svh"
module box_average_downscaler_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // in_red, in_green, in_blue, in_alpha from bit 0 up
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_red, out_green, out_blue, out_alpha from bit 0 up
    output logic      [31:0] m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam int SW = bad_pkg::SIZE_W;
    localparam int CW = bad_pkg::COL_W;
    localparam int RW = bad_pkg::ROW_W;

    typedef enum logic [1:0] { ST_IN, ST_RMW, ST_DIV, ST_PUSH } state_t;
    typedef enum logic [1:0] { SU_IDLE, SU_START, SU_RUN, SU_AREA } setup_t;

    logic [SW-1:0] src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
    logic [SW-1:0] sw_eff, sh_eff, tw_eff, th_eff;
    logic [SW-1:0] bw_reg, rw_reg, bh_reg, rh_reg;
    logic [bad_pkg::AREA_W-1:0] area_reg;
    setup_t setup_reg;
    state_t state_reg;

    logic [CW-1:0] col_reg, tc_reg, wsc_reg;
    logic [RW-1:0] row_reg, tr_reg, wsr_reg;
    logic [SW-1:0] remc_reg, remr_reg;

    logic cfg_wr;
    logic [1:0] cfg_idx;
    logic wdiv_busy, hdiv_busy;
    logic [SW-1:0] wq, wr, hq, hr;
    logic in_acc;

    logic [SW-1:0] col_last, row_last;
    logic hit_col, hit_row, emit, fend, tc_adv, row_wrap, tr_adv, frame_wrap;
    logic [SW:0] remc_sum, remr_sum;
    logic carry_c, carry_r;

    bad_pkg::pix_vec_t px_reg;
    logic hit_reg, first_reg, emit_reg, fend_reg, fend_hold_reg;
    logic [CW-1:0] addr_reg;
    bad_pkg::sum_vec_t rd_sums, new_sums;
    logic [bad_pkg::RAM_W-1:0] ram_rdata;

    logic avg_done;
    bad_pkg::pix_vec_t avg_q;
    bad_pkg::pix_vec_t avg_hold_reg;

    logic out_valid_reg, out_last_reg;
    logic [31:0] out_data_reg;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];
    assign pready = 1'b1;

    always_comb
    begin
        unique case (bad_pkg::reg_index_t'(cfg_idx))
            bad_pkg::REG_SOURCE_WIDTH:  prdata = 32'(src_w_reg);
            bad_pkg::REG_SOURCE_HEIGHT: prdata = 32'(src_h_reg);
            bad_pkg::REG_TARGET_WIDTH:  prdata = 32'(tgt_w_reg);
            bad_pkg::REG_TARGET_HEIGHT: prdata = 32'(tgt_h_reg);
            default:                    prdata = '0;
        endcase
    end

    assign sw_eff = (src_w_reg == '0) ? SW'(1) :
        (src_w_reg > SW'(bad_pkg::MAX_WIDTH)) ? SW'(bad_pkg::MAX_WIDTH) : src_w_reg;
    assign sh_eff = (src_h_reg == '0) ? SW'(1) :
        (src_h_reg > SW'(bad_pkg::MAX_HEIGHT)) ? SW'(bad_pkg::MAX_HEIGHT) : src_h_reg;
    assign tw_eff = (tgt_w_reg == '0) ? SW'(1) : (tgt_w_reg > sw_eff) ? sw_eff : tgt_w_reg;
    assign th_eff = (tgt_h_reg == '0) ? SW'(1) : (tgt_h_reg > sh_eff) ? sh_eff : tgt_h_reg;

    bad_div u_wdiv (
        .clk(clk), .rst_n(rst_n), .start(setup_reg == SU_START),
        .dividend(sw_eff), .divisor(tw_eff), .busy(wdiv_busy),
        .quotient(wq), .remainder(wr)
    );

    bad_div u_hdiv (
        .clk(clk), .rst_n(rst_n), .start(setup_reg == SU_START),
        .dividend(sh_eff), .divisor(th_eff), .busy(hdiv_busy),
        .quotient(hq), .remainder(hr)
    );

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IN) && (setup_reg == SU_IDLE);

    assign col_last = SW'({1'b0, wsc_reg}) + bw_reg - 1'b1;
    assign row_last = SW'({1'b0, wsr_reg}) + bh_reg - 1'b1;
    assign hit_col = (col_reg >= wsc_reg) && (SW'({1'b0, col_reg}) <= col_last);
    assign hit_row = (row_reg >= wsr_reg) && (SW'({1'b0, row_reg}) <= row_last);
    assign emit = hit_col && hit_row && (SW'({1'b0, row_reg}) == row_last)
        && (SW'({1'b0, col_reg}) == col_last);
    assign fend = (SW'({1'b0, tc_reg}) + 1'b1 == tw_eff)
        && (SW'({1'b0, tr_reg}) + 1'b1 == th_eff);
    assign tc_adv = hit_col && (SW'({1'b0, col_reg}) == col_last)
        && (SW'({1'b0, tc_reg}) + 1'b1 < tw_eff);
    assign row_wrap = SW'({1'b0, col_reg}) + 1'b1 >= sw_eff;
    assign tr_adv = row_wrap && hit_row && (SW'({1'b0, row_reg}) == row_last)
        && (SW'({1'b0, tr_reg}) + 1'b1 < th_eff);
    assign frame_wrap = row_wrap && (SW'({1'b0, row_reg}) + 1'b1 >= sh_eff);

    assign remc_sum = {1'b0, remc_reg} + {1'b0, rw_reg};
    assign remr_sum = {1'b0, remr_reg} + {1'b0, rh_reg};
    assign carry_c = remc_sum >= {1'b0, tw_eff};
    assign carry_r = remr_sum >= {1'b0, th_eff};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= SW'(bad_pkg::MAX_WIDTH);
            src_h_reg <= SW'(bad_pkg::MAX_HEIGHT);
            tgt_w_reg <= SW'(bad_pkg::MAX_WIDTH);
            tgt_h_reg <= SW'(bad_pkg::MAX_HEIGHT);
            bw_reg <= SW'(1);
            rw_reg <= '0;
            bh_reg <= SW'(1);
            rh_reg <= '0;
            area_reg <= bad_pkg::AREA_W'(1);
            setup_reg <= SU_IDLE;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (bad_pkg::reg_index_t'(cfg_idx))
                    bad_pkg::REG_SOURCE_WIDTH:  src_w_reg <= pwdata[SW-1:0];
                    bad_pkg::REG_SOURCE_HEIGHT: src_h_reg <= pwdata[SW-1:0];
                    bad_pkg::REG_TARGET_WIDTH:  tgt_w_reg <= pwdata[SW-1:0];
                    bad_pkg::REG_TARGET_HEIGHT: tgt_h_reg <= pwdata[SW-1:0];
                    default:                    src_w_reg <= src_w_reg;
                endcase
                setup_reg <= SU_START;
            end
            else
            begin
                unique case (setup_reg)
                    SU_START: setup_reg <= SU_RUN;
                    SU_RUN:
                    begin
                        if (!wdiv_busy && !hdiv_busy)
                        begin
                            bw_reg <= wq;
                            rw_reg <= wr;
                            bh_reg <= hq;
                            rh_reg <= hr;
                            setup_reg <= SU_AREA;
                        end
                    end
                    SU_AREA:
                    begin
                        area_reg <= bad_pkg::AREA_W'(bw_reg * bh_reg);
                        setup_reg <= SU_IDLE;
                    end
                    default: setup_reg <= SU_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            tc_reg <= '0;
            tr_reg <= '0;
            wsc_reg <= '0;
            wsr_reg <= '0;
            remc_reg <= '0;
            remr_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_reg <= '0;
            row_reg <= '0;
            tc_reg <= '0;
            tr_reg <= '0;
            wsc_reg <= '0;
            wsr_reg <= '0;
            remc_reg <= '0;
            remr_reg <= '0;
        end
        else if (in_acc)
        begin
            if (row_wrap)
            begin
                col_reg <= '0;
                tc_reg <= '0;
                wsc_reg <= '0;
                remc_reg <= '0;
                if (frame_wrap)
                begin
                    row_reg <= '0;
                    tr_reg <= '0;
                    wsr_reg <= '0;
                    remr_reg <= '0;
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                    if (tr_adv)
                    begin
                        tr_reg <= tr_reg + 1'b1;
                        wsr_reg <= RW'(SW'({1'b0, wsr_reg}) + bh_reg + SW'(carry_r));
                        remr_reg <= carry_r ? SW'(remr_sum - {1'b0, th_eff}) : SW'(remr_sum);
                    end
                end
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
                if (tc_adv)
                begin
                    tc_reg <= tc_reg + 1'b1;
                    wsc_reg <= CW'(SW'({1'b0, wsc_reg}) + bw_reg + SW'(carry_c));
                    remc_reg <= carry_c ? SW'(remc_sum - {1'b0, tw_eff}) : SW'(remc_sum);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            px_reg <= s_axis_tdata;
            addr_reg <= tc_reg;
            first_reg <= row_reg == wsr_reg;
            fend_reg <= fend;
        end
    end

    assign rd_sums = ram_rdata;

    always_comb
    begin
        for (int c = 0; c < bad_pkg::CH; c++)
        begin
            new_sums[c] = first_reg ? bad_pkg::SUM_W'(px_reg[c])
                : rd_sums[c] + bad_pkg::SUM_W'(px_reg[c]);
        end
    end

    bad_ram #(.WIDTH(bad_pkg::RAM_W), .DEPTH(bad_pkg::MAX_WIDTH)) u_sums (
        .clk(clk),
        .en(in_acc || (state_reg == ST_RMW)),
        .we((state_reg == ST_RMW) && hit_reg),
        .addr(in_acc ? tc_reg : addr_reg),
        .wdata(new_sums),
        .rdata(ram_rdata)
    );

    bad_avg u_avg (
        .clk(clk), .rst_n(rst_n),
        .start((state_reg == ST_RMW) && emit_reg),
        .sums(new_sums), .area(area_reg),
        .done(avg_done), .quotients(avg_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IN;
            hit_reg <= 1'b0;
            emit_reg <= 1'b0;
            fend_hold_reg <= 1'b0;
            avg_hold_reg <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready && (state_reg != ST_PUSH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IN:
                begin
                    if (in_acc)
                    begin
                        hit_reg <= hit_col && hit_row;
                        emit_reg <= emit;
                        state_reg <= ST_RMW;
                    end
                end
                ST_RMW:
                begin
                    fend_hold_reg <= fend_reg;
                    state_reg <= emit_reg ? ST_DIV : ST_IN;
                end
                ST_DIV:
                begin
                    if (avg_done)
                    begin
                        avg_hold_reg <= avg_q;
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= avg_hold_reg;
                        out_last_reg <= fend_hold_reg;
                        state_reg <= ST_IN;
                    end
                end
                default: state_reg <= ST_IN;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tlast = out_last_reg;

    `BAD_ASSERT_NEXT(a_accept_reads, clk, rst_n, in_acc, state_reg == ST_RMW)
    `BAD_ASSERT_IMPLIES(a_ready_setup, clk, rst_n, s_axis_tready, !wdiv_busy && !hdiv_busy)
    `BAD_ASSERT_IMPLIES(a_done_in_div, clk, rst_n, avg_done, state_reg == ST_DIV)
endmodule
`default_nettype wire

>>> tb/tb_box_average_downscaler_unit.sv
`default_nettype none
module tb_box_average_downscaler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       frame_end;
    } avg_pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    box_average_downscaler_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #10 clk = ~clk;

    // Predictor state.
    logic [11:0] size_reg [4];
    logic [29:0] col_sum [bad_pkg::MAX_WIDTH][4];
    int unsigned src_col, src_row, tgt_col, tgt_row, win_col, win_row;

    avg_pixel_t  pending_pixels [$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    longint      cycle_count = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic int unsigned eff_size(input logic [11:0] v, input int unsigned top);
        if (v == 0)
        begin
            return 1;
        end
        return (v > top) ? top : v;
    endfunction

    function automatic void restart_position();
        src_col = 0;
        src_row = 0;
        tgt_col = 0;
        tgt_row = 0;
        win_col = 0;
        win_row = 0;
    endfunction

    function automatic void predict_pixel(input logic [31:0] pix);
        int unsigned sw, sh, tw, th, bw, bh, col_last, row_last, area;
        bit          in_col, in_row;
        avg_pixel_t  res;
        sw = eff_size(size_reg[bad_pkg::REG_SOURCE_WIDTH], bad_pkg::MAX_WIDTH);
        sh = eff_size(size_reg[bad_pkg::REG_SOURCE_HEIGHT], bad_pkg::MAX_HEIGHT);
        tw = eff_size(size_reg[bad_pkg::REG_TARGET_WIDTH], sw);
        th = eff_size(size_reg[bad_pkg::REG_TARGET_HEIGHT], sh);
        bw = sw / tw;
        bh = sh / th;
        col_last = win_col + bw - 1;
        row_last = win_row + bh - 1;
        in_col = src_col >= win_col && src_col <= col_last;
        in_row = src_row >= win_row && src_row <= row_last;
        if (in_col && in_row)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (src_row == win_row)
                begin
                    col_sum[tgt_col][c] = pix[8*c +: 8];
                end
                else
                begin
                    col_sum[tgt_col][c] = col_sum[tgt_col][c] + pix[8*c +: 8];
                end
            end
            if (src_row == row_last && src_col == col_last)
            begin
                area = bw * bh;
                res.red = col_sum[tgt_col][0] / area;
                res.green = col_sum[tgt_col][1] / area;
                res.blue = col_sum[tgt_col][2] / area;
                res.alpha = col_sum[tgt_col][3] / area;
                res.frame_end = (tgt_col + 1 == tw) && (tgt_row + 1 == th);
                pending_pixels.push_back(res);
            end
        end
        if (in_col && src_col == col_last && tgt_col + 1 < tw)
        begin
            tgt_col++;
            win_col = tgt_col * sw / tw;
        end
        if (src_col + 1 >= sw)
        begin
            src_col = 0;
            tgt_col = 0;
            win_col = 0;
            if (in_row && src_row == row_last && tgt_row + 1 < th)
            begin
                tgt_row++;
                win_row = tgt_row * sh / th;
            end
            if (src_row + 1 >= sh)
            begin
                restart_position();
            end
            else
            begin
                src_row++;
            end
        end
        else
        begin
            src_col++;
        end
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("[box_average_downscaler_unit] ERROR");
            $finish;
        end
    end

    // Result checker and receiver stall.
    always @(posedge clk)
    begin
        avg_pixel_t exp_pix;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("unexpected output beat");
            end
            else
            begin
                exp_pix = pending_pixels.pop_front();
                if (m_axis_tdata[7:0] !== exp_pix.red)
                    report_mismatch($sformatf("red %0d exp %0d", m_axis_tdata[7:0], exp_pix.red));
                if (m_axis_tdata[15:8] !== exp_pix.green)
                    report_mismatch($sformatf("green %0d exp %0d", m_axis_tdata[15:8],
                        exp_pix.green));
                if (m_axis_tdata[23:16] !== exp_pix.blue)
                    report_mismatch($sformatf("blue %0d exp %0d", m_axis_tdata[23:16],
                        exp_pix.blue));
                if (m_axis_tdata[31:24] !== exp_pix.alpha)
                    report_mismatch($sformatf("alpha %0d exp %0d", m_axis_tdata[31:24],
                        exp_pix.alpha));
                if (m_axis_tlast !== exp_pix.frame_end)
                    report_mismatch($sformatf("tlast %0b exp %0b", m_axis_tlast,
                        exp_pix.frame_end));
            end
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_pixel(input logic [31:0] pix);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        predict_pixel(pix);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
    endtask

    task automatic write_size(input bad_pkg::reg_index_t idx, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        size_reg[idx] = value[11:0];
        restart_position();
        @(negedge clk);
    endtask

    task automatic set_sizes(input int sw, input int sh, input int tw, input int th);
        wait_drained();
        write_size(bad_pkg::REG_SOURCE_WIDTH, sw);
        write_size(bad_pkg::REG_SOURCE_HEIGHT, sh);
        write_size(bad_pkg::REG_TARGET_WIDTH, tw);
        write_size(bad_pkg::REG_TARGET_HEIGHT, th);
    endtask

    task automatic send_frames(input int count, input bit extremes);
        logic [31:0] pix;
        for (int i = 0; i < count; i++)
        begin
            pix = $urandom;
            if (extremes)
            begin
                pix = (i % 2) ? 32'hFFFF_FFFF : 32'h0;
            end
            send_pixel(pix);
        end
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_directed();
        set_sizes(2, 2, 1, 1);
        send_frames(4, 1'b1);
        send_frames(4, 1'b0);
        set_sizes(3, 3, 9, 9);
        send_frames(9, 1'b1);
        set_sizes(0, 0, 0, 0);
        send_frames(2, 1'b0);
    endtask

    task automatic test_partial_frame_drop();
        set_sizes(4, 3, 2, 1);
        send_frames(5, 1'b0);
        wait_drained();
        write_size(bad_pkg::REG_TARGET_HEIGHT, 1);
        send_frames(12, 1'b0);
    endtask

    task automatic test_wide_rows();
        set_sizes(2048, 1, 16, 1);
        send_frames(256, 1'b1);
        set_sizes(4095, 1, 2048, 1);
        send_frames(40, 1'b0);
    endtask

    task automatic test_random(input int pixels);
        int sw, sh;
        int sent;
        int count;
        sent = 0;
        while (sent < pixels)
        begin
            sw = $urandom_range(1, 9);
            sh = $urandom_range(1, 9);
            set_sizes(sw, sh, $urandom_range(0, sw + 2), $urandom_range(0, sh + 2));
            count = sw * sh * $urandom_range(1, 3) + $urandom_range(0, 3);
            send_frames(count, 1'b0);
            sent += count;
            if ($urandom_range(9) == 0)
            begin
                wait_drained();
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < 4; i++)
        begin
            size_reg[i] = 12'd2048;
        end
        restart_position();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_partial_frame_drop();
        test_wide_rows();
        test_random(250);
        send_idle_pct = 53;
        test_random(250);
        send_idle_pct = 0;
        recv_stall_pct = 53;
        test_random(250);
        send_idle_pct = 35;
        recv_stall_pct = 35;
        test_random(250);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (error_count == 0)
        begin
            $display("[box_average_downscaler_unit] OK");
        end
        else
        begin
            $display("[box_average_downscaler_unit] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
